@@ rtl/blmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blmd_pkg
// Shared types and constants for the bounded list with match delete.
// ----------------------------------------------------------------------------
package blmd_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  // Move command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // take the left neighbor's value
    logic shift;  // take the right neighbor's value, or the head at the tail slot
  } cell_ctrl_t;

endpackage : blmd_pkg
`default_nettype wire

@@ rtl/blmd_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blmd_cell
// One storage slot of the list chain; moves one step left or right per cycle when commanded, else holds.
// ----------------------------------------------------------------------------
module blmd_cell (
  input  wire                  clk_i,
  input  blmd_pkg::cell_ctrl_t ctrl_i,
  input  blmd_pkg::value_t     left_i,
  input  blmd_pkg::value_t     right_i,
  input  blmd_pkg::value_t     wrap_i,
  input  wire                  tail_sel_i,
  output blmd_pkg::value_t     value_o
);
  import blmd_pkg::*;

  value_t value_d, value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.push) begin
      value_d = left_i;
    end else if (ctrl_i.shift) begin
      // the tail slot catches the entry leaving the head when it survives
      value_d = tail_sel_i ? wrap_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule : blmd_cell
`default_nettype wire

@@ rtl/blmd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blmd_ctrl
// Request sequencer: length tracking, head walk for count and delete, and
// the result register.
// ----------------------------------------------------------------------------
module blmd_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [1:0]                 req_type_i,
  input  blmd_pkg::value_t           value_i,
  input  blmd_pkg::value_t           head_val_i,
  input  blmd_pkg::value_t           next_val_i,
  output blmd_pkg::cell_ctrl_t       cell_ctrl_o,
  output logic [blmd_pkg::DEPTH-1:0] tail_sel_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output blmd_pkg::value_t           head_value_o,
  output blmd_pkg::cnt_t             match_count_o,
  output blmd_pkg::cnt_t             list_length_o,
  output logic                       is_empty_o,
  output logic                       error_o
);
  import blmd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e state_d, state_q;
  req_e   op_d, op_q;
  value_t target_d, target_q;
  cnt_t   count_d, count_q;
  cnt_t   steps_d, steps_q;
  cnt_t   cur_d, cur_q;
  cnt_t   hits_d, hits_q;

  logic   out_valid_d, out_valid_q;
  value_t head_d, head_q;
  cnt_t   match_d, match_q;
  cnt_t   len_d, len_q;
  logic   empty_d, empty_q;
  logic   err_d, err_q;

  logic   accept;
  logic   hit;
  logic   keep;
  req_e   req;

  assign req        = req_e'(req_type_i);
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign hit        = (head_val_i == target_q);
  assign keep       = (state_q == ST_WALK) && ((op_q == REQ_COUNT) || !hit);

  // the surviving head entry lands in the last occupied slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tail_sel_o[i] = keep && (cur_q == CNT_W'(i + 1));
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    target_d    = target_q;
    count_d     = count_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    hits_d      = hits_q;
    out_valid_d = out_valid_q && out_stall_i;
    head_d      = head_q;
    match_d     = match_q;
    len_d       = len_q;
    empty_d     = empty_q;
    err_d       = err_q;
    cell_ctrl_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          match_d = '0;
          err_d   = 1'b0;
          unique case (req)
            REQ_PUSH: begin
              out_valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                err_d   = 1'b1;
                head_d  = head_val_i;
                len_d   = count_q;
                empty_d = 1'b0;
              end else begin
                cell_ctrl_o.push = 1'b1;
                count_d = count_q + 1'b1;
                head_d  = value_i;
                len_d   = count_q + 1'b1;
                empty_d = 1'b0;
              end
            end
            REQ_POP: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                err_d   = 1'b1;
                head_d  = '0;
                len_d   = '0;
                empty_d = 1'b1;
              end else begin
                cell_ctrl_o.shift = 1'b1;
                count_d = count_q - 1'b1;
                head_d  = (count_q > CNT_W'(1)) ? next_val_i : '0;
                len_d   = count_q - 1'b1;
                empty_d = (count_q == CNT_W'(1));
              end
            end
            REQ_COUNT, REQ_DELETE: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                head_d  = '0;
                len_d   = '0;
                empty_d = 1'b1;
              end else begin
                op_d     = req;
                target_d = value_i;
                steps_d  = count_q;
                cur_d    = count_q;
                hits_d   = '0;
                state_d  = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // rotate the head through the chain, dropping matches on delete
        cell_ctrl_o.shift = 1'b1;
        if (hit) begin
          hits_d = hits_q + 1'b1;
        end
        if (!keep) begin
          cur_d = cur_q - 1'b1;
        end
        steps_d = steps_q - 1'b1;
        if (steps_q == CNT_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        count_d     = cur_q;
        out_valid_d = 1'b1;
        head_d      = (cur_q != '0) ? head_val_i : '0;
        match_d     = hits_q;
        len_d       = cur_q;
        empty_d     = (cur_q == '0);
        err_d       = 1'b0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    target_q <= target_d;
    steps_q  <= steps_d;
    cur_q    <= cur_d;
    hits_q   <= hits_d;
    head_q   <= head_d;
    match_q  <= match_d;
    len_q    <= len_d;
    empty_q  <= empty_d;
    err_q    <= err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign head_value_o  = head_q;
  assign match_count_o = match_q;
  assign list_length_o = len_q;
  assign is_empty_o    = empty_q;
  assign error_o       = err_q;

endmodule : blmd_ctrl
`default_nettype wire

@@ rtl/bounded_list_with_match_delete.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_with_match_delete
// Ordered list of up to DEPTH values held in a chain of cells, head first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries req_type_i and value_i:
//   push at head, pop head, count matches, delete all matches.
//   Output channel (out_valid_o / out_stall_i) returns one result per
//   request: head value, match count, length, empty and error flags.
// Timing:
//   Push, pop, and count/delete on an empty list: result is registered the
//   cycle after the transfer. Count and delete on a list of n entries walk
//   the head through the chain one entry per cycle, then register the
//   result. One request is in work at a time.
// Reset:
//   The list length, sequencer state and output valid clear; the cell
//   contents are not reset and are never observed before being written.
// Stall:
//   A stalled result holds in the output register; a new request is taken
//   once that result transfers (same cycle allowed).
// ----------------------------------------------------------------------------
module bounded_list_with_match_delete (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [31:0] value_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] head_value_o,
  output logic [4:0]  match_count_o,
  output logic [4:0]  list_length_o,
  output logic        is_empty_o,
  output logic        error_o
);
  import blmd_pkg::*;

  value_t           cell_val [DEPTH];
  value_t           left_val [DEPTH];
  value_t           right_val[DEPTH];
  cell_ctrl_t       cell_ctrl;
  logic [DEPTH-1:0] tail_sel;

  blmd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .head_val_i    (cell_val[0]),
    .next_val_i    (cell_val[1]),
    .cell_ctrl_o   (cell_ctrl),
    .tail_sel_o    (tail_sel),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .head_value_o  (head_value_o),
    .match_count_o (match_count_o),
    .list_length_o (list_length_o),
    .is_empty_o    (is_empty_o),
    .error_o       (error_o)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_val[g] = value_i;
    end else begin : g_body
      assign left_val[g] = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val[g] = '0;
    end else begin : g_mid
      assign right_val[g] = cell_val[g+1];
    end

    blmd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .left_i     (left_val[g]),
      .right_i    (right_val[g]),
      .wrap_i     (cell_val[0]),
      .tail_sel_i (tail_sel[g]),
      .value_o    (cell_val[g])
    );
  end

endmodule : bounded_list_with_match_delete
`default_nettype wire

@@ rtl/blmd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blmd_checker
// Port-level checks on the list block's results, bound to the top level.
// ----------------------------------------------------------------------------
module blmd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [31:0] head_value_o,
  input wire [4:0]  match_count_o,
  input wire [4:0]  list_length_o,
  input wire        is_empty_o,
  input wire        error_o
);
  import blmd_pkg::*;

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (list_length_o == '0)))
    else $error("empty flag disagrees with length");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (head_value_o == '0))
    else $error("empty list reports nonzero head");

  a_err_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (match_count_o == '0))
    else $error("error result carries a match count");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((list_length_o <= 5'(DEPTH)) && (match_count_o <= 5'(DEPTH))))
    else $error("length or count beyond depth");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(head_value_o)
      && $stable(list_length_o) && $stable(match_count_o)))
    else $error("stalled result changed");

endmodule : blmd_checker

bind bounded_list_with_match_delete blmd_checker u_blmd_checker (.*);
`default_nettype wire

@@ tb/bounded_list_with_match_delete_test.sv @@
// ----------------------------------------------------------------------------
// bounded_list_with_match_delete_test
// Self-checking bench for the bounded list: drives push, pop, count and
// delete requests under varying source gaps and sink back-pressure, tracks
// the list contents in a shadow copy and compares every result in order.
// ----------------------------------------------------------------------------
module bounded_list_with_match_delete_test;
  import blmd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SEGMENTS    = 14;
  localparam int SEG_ITEMS   = 100;

  typedef struct packed {
    value_t head;
    cnt_t   hit_cnt;
    cnt_t   length;
    logic   empty;
    logic   err;
  } list_result_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  class list_checker;
    value_t       slot[DEPTH];
    int           held;
    list_result_t pending_results[$];
    int           mismatches;

    function void note_request(req_e req, value_t val);
      list_result_t want;
      int hits;
      int kept;
      want = '0;
      hits = 0;
      kept = 0;
      case (req)
        REQ_PUSH: begin
          if (held == DEPTH) begin
            want.err = 1'b1;
          end else begin
            for (int i = held; i > 0; i--) slot[i] = slot[i-1];
            slot[0] = val;
            held++;
          end
        end
        REQ_POP: begin
          if (held == 0) begin
            want.err = 1'b1;
          end else begin
            for (int i = 0; i + 1 < held; i++) slot[i] = slot[i+1];
            held--;
          end
        end
        REQ_COUNT: begin
          for (int i = 0; i < held; i++) if (slot[i] == val) hits++;
        end
        REQ_DELETE: begin
          // compact survivors toward the head, keeping their order
          for (int i = 0; i < held; i++) begin
            if (slot[i] != val) begin
              slot[kept] = slot[i];
              kept++;
            end
          end
          hits = held - kept;
          held = kept;
        end
      endcase
      want.head    = (held > 0) ? slot[0] : '0;
      want.hit_cnt = cnt_t'(hits);
      want.length  = cnt_t'(held);
      want.empty   = (held == 0);
      pending_results.push_back(want);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: head %h count %0d len %0d empty %b err %b",
                   got.head, got.hit_cnt, got.length, got.empty, got.err);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.head !== want.head || got.hit_cnt !== want.hit_cnt ||
          got.length !== want.length || got.empty !== want.empty ||
          got.err !== want.err) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected head %h count %0d len %0d empty %b err %b",
                   want.head, want.hit_cnt, want.length, want.empty, want.err);
          $display("          actual   head %h count %0d len %0d empty %b err %b",
                   got.head, got.hit_cnt, got.length, got.empty, got.err);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i  = '0;
  logic [31:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] head_value_o;
  logic [4:0]  match_count_o;
  logic [4:0]  list_length_o;
  logic        is_empty_o;
  logic        error_o;

  list_checker tracker = new();
  int          idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  value_t      value_pool[4];

  bounded_list_with_match_delete dut (.*);

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.head    = head_value_o;
        got.hit_cnt = match_count_o;
        got.length  = list_length_o;
        got.empty   = is_empty_o;
        got.err     = error_o;
        tracker.check_result(got);
      end
      if (in_valid_i && !in_stall_o) tracker.note_request(req_e'(req_type_i), value_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bounded_list_with_match_delete_test NOT OK");
        $finish;
      end
    end
  end

  task set_idling(idling_e mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct  = 59;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 59;
      end
      default: begin
        idle_pct  = 12;
        stall_pct = 12;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_request(req_e req, value_t val);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = req;
    value_i    = val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic req_e pick_request(mix_e mix);
    int r;
    int push_w;
    int pop_w;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        push_w = 55;
        pop_w  = 10;
      end
      MIX_DRAIN: begin
        push_w = 15;
        pop_w  = 50;
      end
      default: begin
        push_w = 30;
        pop_w  = 30;
      end
    endcase
    if (r < push_w) return REQ_PUSH;
    if (r < push_w + pop_w) return REQ_POP;
    if (r < push_w + pop_w + (100 - push_w - pop_w) / 2) return REQ_COUNT;
    return REQ_DELETE;
  endfunction

  // Mostly reuse a few values so that counts and deletes find matches.
  function automatic value_t pick_value();
    if ($urandom_range(9) < 6) return value_pool[$urandom_range(3)];
    return $urandom();
  endfunction

  initial begin
    mix_e mix;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list corner cases
    send_request(REQ_POP, 32'h0);
    send_request(REQ_COUNT, 32'h0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF);
    // fill to the limit; all-ones lands at both head and tail
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 3)
        0: send_request(REQ_PUSH, 32'hFFFF_FFFF);
        1: send_request(REQ_PUSH, 32'h0);
        default: send_request(REQ_PUSH, 32'hA5A5_0000 | i);
      endcase
    end
    send_request(REQ_PUSH, 32'h1234_5678);
    send_request(REQ_COUNT, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 32'h0);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 32'h5A5A_5A5A);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // hold off until every pending result has been returned
      in_valid_i = 1'b0;
      @(negedge clk_i);
      while (tracker.pending_results.size() != 0) @(negedge clk_i);
      set_idling(idling_e'(seg % 4));
      value_pool[0] = $urandom();
      value_pool[1] = $urandom();
      value_pool[2] = (seg % 2) ? 32'hFFFF_FFFF : 32'h0;
      value_pool[3] = $urandom();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n % 50 == 0) mix = mix_e'($urandom_range(2));
        send_request(pick_request(mix), pick_value());
      end
    end

    in_valid_i = 1'b0;
    set_idling(IDLE_NONE);
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 4) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("bounded_list_with_match_delete_test OK");
    end else begin
      $display("bounded_list_with_match_delete_test NOT OK");
    end
    $finish;
  end

endmodule

@@ bounded_list_with_match_delete.f @@
rtl/blmd_pkg.sv
rtl/blmd_cell.sv
rtl/blmd_ctrl.sv
rtl/bounded_list_with_match_delete.sv
rtl/blmd_checker.sv
tb/bounded_list_with_match_delete_test.sv
